// ===== hdl/gsr_pkg.sv =====
// shared types and constants of the game-pad serial responder
`default_nettype none
package gsr_pkg;
   localparam logic [7:0] CMD_READ    = 8'h42;
   localparam logic [7:0] CMD_CONFIG  = 8'h43;
   localparam logic [7:0] CMD_SETMODE = 8'h44;
   localparam logic [7:0] CMD_MODEL   = 8'h45;
   localparam logic [7:0] CMD_ACT     = 8'h46;
   localparam logic [7:0] CMD_COMB    = 8'h47;
   localparam logic [7:0] CMD_QMODE   = 8'h4C;
   localparam logic [7:0] CMD_TOGGLE  = 8'h4D;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      TBL_DATA, TBL_SETMODE, TBL_MODEL, TBL_ACT, TBL_COMB, TBL_QMODE, TBL_TOGGLE, TBL_CFG
   } tbl_type;

   typedef struct packed {
      logic       start;
      logic       analog;
      logic [7:0] host_byte;
      logic [15:0] buttons;
      logic [31:0] axes;
   } item_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic [7:0] motor_small;
      logic [7:0] motor_large;
   } result_type;
endpackage
`default_nettype wire

// ===== hdl/gamepad_serial_responder.sv =====
// top level of the game-pad serial responder
// use: each req_ transfer is one event of the console link: tuser 0 marks the
// start of a poll frame, tuser 1 exchanges one byte. every request gives exactly
// one rsp_ transfer carrying the reply byte and both latched motor levels.
// csr_ writes the analog-pad setting; write it only while the block is idle.
// a request passes through the input queue, then the protocol engine with its
// output register.
// throughput: one transfer per cycle while the receiver does not stall.
// the two-entry input queue lets requests keep arriving while a response
// waits; if the receiver stalls, the queue fills and req_tready drops.
// reset: pad state returns to digital mode, id 0x41, motors off, analog
// setting 1; queue and output register empty.
`default_nettype none
module gamepad_serial_responder
   import gsr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // host_byte, button_bits, right_x, right_y, left_x, left_y
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // reply_byte, motor_small, motor_large
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);
   logic       analog_ff;
   item_type   item, q_item;
   logic       q_valid, q_ready;
   result_type res;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) analog_ff <= 1'b1;
      else if (csr_valid) analog_ff <= csr_data;
   end

   always_comb begin
      item.start     = req_tuser;
      item.analog    = analog_ff;
      item.host_byte = req_tdata[7:0];
      item.buttons   = req_tdata[23:8];
      item.axes      = req_tdata[55:24];
   end

   gsr_front #(.DEPTH(DEPTH)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_item(item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   gsr_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {res.motor_large, res.motor_small, res.reply_byte};
endmodule
`default_nettype wire

// ===== hdl/gsr_front.sv =====
// input stage: takes transfers, already tagged with the analog setting by the top level, and queues them
`default_nettype none
module gsr_front
   import gsr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   item_type          mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ===== hdl/gsr_back.sv =====
// protocol engine: per-byte state update, reply selection and output register
`default_nettype none
module gsr_back
   import gsr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_result
);
   logic [3:0]  byte_pos_ff, byte_pos_in, frame_len_ff, frame_len_in;
   logic [7:0]  cmd_ff, cmd_in;
   tbl_type     sel_ff, sel_in;
   logic [7:0]  amode_ff, amode_in, cflag_ff, cflag_in, pad_id_ff, pad_id_in;
   logic [3:0]  slot_ff [2];
   logic [3:0]  slot_in [2];
   logic [7:0]  motor_ff [2];
   logic [7:0]  motor_in [2];
   logic [15:0] btn_ff, btn_in;
   logic [31:0] axes_ff, axes_in;
   logic [23:0] tail_ff, tail_in;
   logic [7:0]  mrep_ff, mrep_in;
   logic [5:0]  tog_ff, tog_in;
   logic        valid_ff;
   result_type  res_ff, res_in;
   logic        take;
   logic [7:0]  v, reply, c;
   logic [2:0]  p;
   logic [2:0]  half;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = res_ff;
   assign take = in_valid && in_ready;
   assign v = in_item.host_byte;
   assign p = byte_pos_ff[2:0];

   function automatic logic [7:0] tbl_byte(input tbl_type s, input logic [2:0] q,
         input logic [15:0] b, input logic [31:0] a, input logic [7:0] am,
         input logic [23:0] t, input logic [7:0] mr, input logic [5:0] tg);
      logic [7:0] r;
      r = 8'h00;
      if (q == 3'd0) r = 8'hFF;
      else if (q == 3'd1) r = 8'h5A;
      else begin
         unique case (s)
            TBL_DATA: begin
               case (q)
                  3'd2: r = b[7:0];
                  3'd3: r = b[15:8];
                  3'd4: r = a[7:0];
                  3'd5: r = a[15:8];
                  3'd6: r = a[23:16];
                  default: r = a[31:24];
               endcase
            end
            TBL_MODEL: begin
               case (q)
                  3'd2: r = 8'h01;
                  3'd3: r = 8'h02;
                  3'd4: r = am;
                  3'd5: r = 8'h02;
                  3'd6: r = 8'h01;
                  default: r = 8'h00;
               endcase
            end
            TBL_ACT: begin
               case (q)
                  3'd4: r = 8'h01;
                  3'd5: r = t[7:0];
                  3'd6: r = t[15:8];
                  3'd7: r = t[23:16];
                  default: r = 8'h00;
               endcase
            end
            TBL_COMB: r = (q == 3'd4) ? 8'h02 : (q == 3'd6) ? 8'h01 : 8'h00;
            TBL_QMODE: r = (q == 3'd5) ? mr : 8'h00;
            TBL_TOGGLE: r = tg[q - 3'd2] ? 8'hFF : 8'h00;
            default: r = 8'h00;
         endcase
      end
      return r;
   endfunction

   always_comb begin
      byte_pos_in = byte_pos_ff; frame_len_in = frame_len_ff; cmd_in = cmd_ff;
      sel_in = sel_ff; amode_in = amode_ff; cflag_in = cflag_ff; pad_id_in = pad_id_ff;
      slot_in = slot_ff; motor_in = motor_ff; btn_in = btn_ff; axes_in = axes_ff;
      tail_in = tail_ff; mrep_in = mrep_ff; tog_in = tog_ff;
      reply = 8'hFF;
      c = in_item.analog ? v : CMD_READ;
      half = 3'((4'(p) - 4'd1) >> 1);
      if (!in_item.start) begin
         byte_pos_in = '0;
      end else if (byte_pos_ff == '0) begin
         cmd_in = c; byte_pos_in = 4'd1; frame_len_in = 4'd8; reply = 8'hF3;
         unique case (c)
            CMD_SETMODE: sel_in = TBL_SETMODE;
            CMD_MODEL:   sel_in = TBL_MODEL;
            CMD_ACT:     sel_in = TBL_ACT;
            CMD_COMB:    sel_in = TBL_COMB;
            CMD_QMODE:   sel_in = TBL_QMODE;
            CMD_TOGGLE:  sel_in = TBL_TOGGLE;
            default: begin
               if (c == CMD_CONFIG && cflag_ff != '0) sel_in = TBL_CFG;
               else begin
                  sel_in = TBL_DATA; btn_in = in_item.buttons; reply = pad_id_ff;
                  if (amode_ff == 8'd1) axes_in = in_item.axes;
                  else frame_len_in = 4'd4;
               end
            end
         endcase
      end else if (byte_pos_ff < frame_len_ff) begin
         if (p == 3'd2) begin
            unique case (cmd_ff)
               CMD_CONFIG: cflag_in = v;
               CMD_SETMODE: begin
                  amode_in = v; pad_id_in = (v != '0) ? 8'h73 : 8'h41;
               end
               CMD_ACT: begin
                  if (v == 8'd0) tail_in = 24'h0A0002;
                  else if (v == 8'd1) tail_in = 24'h140101;
               end
               CMD_QMODE: begin
                  if (v == 8'd0) mrep_in = 8'd4;
                  else if (v == 8'd1) mrep_in = 8'd7;
               end
               default: ;
            endcase
         end
         if (in_item.analog) begin
            if (cmd_ff == CMD_READ) begin
               for (int i = 0; i < 2; i++)
                  if (slot_ff[i] == byte_pos_ff) motor_in[i] = v;
            end else if (cmd_ff == CMD_TOGGLE) begin
               for (int i = 0; i < 2; i++)
                  if (slot_ff[i] == byte_pos_ff && p >= 3'd2) tog_in[p - 3'd2] = 1'b0;
               if (v < 8'd2) begin
                  slot_in[v[0]] = byte_pos_ff;
                  if (pad_id_ff[3:0] < {1'b0, half})
                     pad_id_in = {pad_id_ff[7:4], 1'b0, half};
               end
            end
         end
         reply = tbl_byte(sel_ff, p, btn_ff, axes_ff, amode_ff, tail_ff, mrep_ff, tog_in);
         byte_pos_in = byte_pos_ff + 4'd1;
      end
      res_in.reply_byte  = reply;
      res_in.motor_small = motor_in[0];
      res_in.motor_large = motor_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; byte_pos_ff <= '0; frame_len_ff <= '0; cmd_ff <= '0;
         sel_ff <= TBL_DATA; amode_ff <= '0; cflag_ff <= '0; pad_id_ff <= 8'h41;
         slot_ff[0] <= 4'hF; slot_ff[1] <= 4'hF; motor_ff[0] <= '0; motor_ff[1] <= '0;
         btn_ff <= 16'hFFFF; axes_ff <= {4{8'h80}}; tail_ff <= 24'h0A0002;
         mrep_ff <= '0; tog_ff <= '1;
      end else begin
         valid_ff <= take || (valid_ff && !out_ready);
         if (take) begin
            res_ff <= res_in;
            byte_pos_ff <= byte_pos_in; frame_len_ff <= frame_len_in; cmd_ff <= cmd_in;
            sel_ff <= sel_in; amode_ff <= amode_in; cflag_ff <= cflag_in;
            pad_id_ff <= pad_id_in; slot_ff <= slot_in; motor_ff <= motor_in;
            btn_ff <= btn_in; axes_ff <= axes_in; tail_ff <= tail_in;
            mrep_ff <= mrep_in; tog_ff <= tog_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== bench/gamepad_serial_responder_checker.sv =====
// checker for the game-pad serial responder: predicts replies and compares transfers
module gamepad_serial_responder_checker
   import gsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic        pad_analog;
   logic [3:0]  pos, flen;
   logic [7:0]  cmd_now;
   tbl_type     tsel;
   logic [7:0]  amode, cflag, id;
   logic [3:0]  slot [2];
   logic [7:0]  motor [2];
   logic [15:0] btn;
   logic [7:0]  axis [4];
   logic [7:0]  act_tail [3];
   logic [7:0]  qmode_byte;
   logic [7:0]  tog [6];
   logic [23:0] replies_due [$];

   localparam logic [7:0] MODEL_TBL [8] = '{8'hFF, 8'h5A, 8'h01, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
   localparam logic [7:0] ACT_TBL [8]   = '{8'hFF, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] COMB_TBL [8]  = '{8'hFF, 8'h5A, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00};

   assign pending = replies_due.size();

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic logic [7:0] reply_table(input logic [2:0] p);
      case (p)
         3'd0: return 8'hFF;
         3'd1: return 8'h5A;
         default: ;
      endcase
      case (tsel)
         TBL_DATA: begin
            if (p == 2) return btn[7:0];
            if (p == 3) return btn[15:8];
            return axis[p - 4];
         end
         TBL_MODEL: return (p == 4) ? amode : MODEL_TBL[p];
         TBL_ACT: return (p >= 5) ? act_tail[p - 5] : ACT_TBL[p];
         TBL_COMB: return COMB_TBL[p];
         TBL_QMODE: return (p == 5) ? qmode_byte : 8'h00;
         TBL_TOGGLE: return tog[p - 2];
         default: return 8'h00;
      endcase
   endfunction

   task automatic exchange(input logic start, input logic [55:0] d);
      logic [7:0] v, r, c;
      logic [2:0] p;
      int half;
      v = d[7:0];
      if (!start) begin
         pos = 0;
         r = 8'hFF;
      end else if (pos == 0) begin
         c = pad_analog ? v : CMD_READ;
         cmd_now = c;
         pos = 1;
         flen = 8;
         r = 8'hF3;
         case (c)
            CMD_SETMODE: tsel = TBL_SETMODE;
            CMD_MODEL:   tsel = TBL_MODEL;
            CMD_ACT:     tsel = TBL_ACT;
            CMD_COMB:    tsel = TBL_COMB;
            CMD_QMODE:   tsel = TBL_QMODE;
            CMD_TOGGLE:  tsel = TBL_TOGGLE;
            default: begin
               if (c == CMD_CONFIG && cflag != 0) begin
                  tsel = TBL_CFG;
               end else begin
                  tsel = TBL_DATA;
                  btn = d[23:8];
                  if (amode == 1) begin
                     for (int i = 0; i < 4; i++) axis[i] = d[24 + 8*i +: 8];
                  end else begin
                     flen = 4;
                  end
                  r = id;
               end
            end
         endcase
      end else if (pos >= flen) begin
         r = 8'hFF;
      end else begin
         p = pos[2:0];
         if (p == 2) begin
            case (cmd_now)
               CMD_CONFIG: cflag = v;
               CMD_SETMODE: begin
                  amode = v;
                  id = (v != 0) ? 8'h73 : 8'h41;
               end
               CMD_ACT: begin
                  if (v == 0) act_tail = '{8'h02, 8'h00, 8'h0A};
                  else if (v == 1) act_tail = '{8'h01, 8'h01, 8'h14};
               end
               CMD_QMODE: begin
                  if (v == 0) qmode_byte = 4;
                  else if (v == 1) qmode_byte = 7;
               end
               default: ;
            endcase
         end
         if (pad_analog) begin
            if (cmd_now == CMD_READ) begin
               for (int i = 0; i < 2; i++) if (slot[i] == p) motor[i] = v;
            end else if (cmd_now == CMD_TOGGLE) begin
               for (int i = 0; i < 2; i++) if (slot[i] == p && p >= 2) tog[p - 2] = 0;
               if (v < 2) begin
                  half = (p - 1) / 2;
                  slot[v[0]] = {1'b0, p};
                  if (id[3:0] < half) id = {id[7:4], 4'(half)};
               end
            end
         end
         r = reply_table(p);
         pos = pos + 1;
      end
      replies_due.push_back({motor[1], motor[0], r});
   endtask

   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         pad_analog = 1; pos = 0; flen = 0; cmd_now = 0; tsel = TBL_DATA;
         amode = 0; cflag = 0; id = 8'h41;
         slot = '{4'd15, 4'd15}; motor = '{8'd0, 8'd0};
         btn = 16'hFFFF; axis = '{8'h80, 8'h80, 8'h80, 8'h80};
         act_tail = '{8'h02, 8'h00, 8'h0A}; qmode_byte = 0;
         tog = '{default: 8'hFF};
         replies_due.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) pad_analog = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $display("unexpected response transfer %06h at %0t", rsp_tdata, $realtime);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_tdata[7:0] !== want[7:0]) report("reply_byte", rsp_tdata[7:0], want[7:0]);
               if (rsp_tdata[15:8] !== want[15:8])
                  report("motor_small", rsp_tdata[15:8], want[15:8]);
               if (rsp_tdata[23:16] !== want[23:16])
                  report("motor_large", rsp_tdata[23:16], want[23:16]);
            end
         end
         if (req_tvalid && req_tready) exchange(req_tuser, req_tdata);
      end
   end
endmodule

// ===== bench/gamepad_serial_responder_tb.sv =====
// testbench top: stimulus, flow control and verdict for the game-pad serial responder
module gamepad_serial_responder_tb;
   import gsr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_data = 0;
   int          fail_count, pending;
   int          cycle = 0;
   bit          calm = 0;
   bit          hold_off = 0;
   bit          done = 0;

   localparam logic [7:0] COMMANDS [8] = '{CMD_READ, CMD_CONFIG, CMD_SETMODE, CMD_MODEL,
                                           CMD_ACT, CMD_COMB, CMD_QMODE, CMD_TOGGLE};
   localparam int MARKS [4] = '{500, 650, 800, 900};

   always #2 clock = ~clock;

   gamepad_serial_responder u_dut (.*);

   gamepad_serial_responder_checker u_chk (.*);

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !reset && !hold_off && (calm || $urandom_range(99) >= 21);

   task automatic send(input logic start, input logic [7:0] hb);
      logic [55:0] d;
      d = 56'({$urandom, $urandom});
      d[7:0] = hb;
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= start;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic frame(input logic [7:0] cmd, input int len);
      send(0, 8'hFF);
      send(1, cmd);
      for (int i = 0; i < len; i++)
         send(1, ($urandom_range(3) != 0) ? 8'($urandom_range(2)) : 8'($urandom));
   endtask

   task automatic set_analog(input logic v);
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      int n, len, k;
      bit held;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: stray bytes, every command, extremes of host byte
      send(1, 8'h00);
      frame(CMD_READ, 10);
      frame(CMD_SETMODE, 3);
      send(0, 8'h00);
      send(1, CMD_SETMODE);
      send(1, 8'h00);
      send(1, 8'h01);
      frame(CMD_CONFIG, 2);
      frame(8'hFF, 9);
      frame(8'h00, 2);
      for (int i = 0; i < 8; i++) frame(COMMANDS[i], 8);
      set_analog(0);
      frame(CMD_TOGGLE, 8);
      frame(CMD_SETMODE, 8);
      set_analog(1);
      // random: mostly well-formed frames
      n = 0;
      k = 0;
      held = 0;
      while (n < 960) begin
         calm = (n >= 300 && n < 450);
         if (n >= 600 && !held) begin
            held = 1;
            fork
               begin
                  hold_off = 1;
                  repeat (60) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         end
         if (k < 4 && n >= MARKS[k]) begin
            set_analog(k[0]);
            k++;
         end
         case ($urandom_range(9))
            0: begin
               send(1'($urandom_range(1)), 8'($urandom));
               n++;
            end
            1: begin
               len = $urandom_range(9);
               frame(8'($urandom), len);
               n += 2 + len;
            end
            default: begin
               len = $urandom_range(4, 9);
               frame(COMMANDS[$urandom_range(7)], len);
               n += 2 + len;
            end
         endcase
      end
      calm = 0;
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      done = 1;
   end

   always @(posedge clock) begin
      if (done) begin
         if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
         end else begin
            $display("simulation failed");
         end
         $finish;
      end
   end
endmodule

// ===== filelist.f =====
hdl/gsr_pkg.sv
hdl/gsr_front.sv
hdl/gsr_back.sv
hdl/gamepad_serial_responder.sv
bench/gamepad_serial_responder_checker.sv
bench/gamepad_serial_responder_tb.sv
